FILE: rtl/core/pevrt_pkg.sv
// ----------------------------------------------------------------------------
// pevrt_pkg: shared types and constants
// Request payload structs and default sizes for the pose error tracker.
// ----------------------------------------------------------------------------
package pevrt_pkg;

  localparam int RING_DEPTH_DEF  = 64;
  localparam int COUNT_LIMIT_DEF = 1048575;
  localparam logic [24:0] LIMIT_RESET = 25'd10000;

  localparam logic CMD_REF  = 1'b0;
  localparam logic CMD_POSE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [47:0]        time_us;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } in_req_t;

  typedef struct packed {
    logic [47:0] time_gap_us;
    logic [23:0] err_x;
    logic [23:0] err_y;
    logic [23:0] err_z;
    logic [24:0] err_distance;
    logic        accepted;
    logic        no_reference;
    logic [19:0] accepted_total;
    logic [23:0] peak_x;
    logic [23:0] peak_y;
    logic [23:0] peak_z;
    logic [24:0] peak_distance;
  } out_req_t;

endpackage

FILE: rtl/core/pose_error_vs_reference_tracker_unit.sv
// ----------------------------------------------------------------------------
// pose_error_vs_reference_tracker_unit: pose error vs reference ring
// Reference request: written at the accepting edge; in_ready stays high. Pose
// request: walks the ring back from the newest entry (S_WAIT, S_CMP), stopping when
// the gap does not shrink or all entries are seen; re-reads the match, then errors,
// squares, sum, 25-step square root (S_ROOT), registered result (S_OUT). Empty ring:
// no-reference result registered at accept. One request at a time, the next once
// the result is taken. Sync reset clears pointers, counters, peaks; ring undefined.
// ----------------------------------------------------------------------------
module pose_error_vs_reference_tracker_unit #(
  parameter int RING_DEPTH  = pevrt_pkg::RING_DEPTH_DEF,
  parameter int COUNT_LIMIT = pevrt_pkg::COUNT_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pevrt_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pevrt_pkg::out_req_t out_data,
  input  logic                cfg_we,
  input  logic [24:0]         cfg_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int CW = $clog2(COUNT_LIMIT + 1);
  localparam logic [AW-1:0] LAST  = AW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] FULL  = FW'(RING_DEPTH);
  localparam logic [CW-1:0] CLIM  = CW'(COUNT_LIMIT);
  localparam pevrt_pkg::out_req_t NO_REF = '{no_reference: 1'b1, default: '0};

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_WAIT, S_CMP, S_MATCH, S_ERR, S_SQ, S_SUM, S_ROOT, S_OUT
  } state_t;

  state_t state;

  logic [119:0] ring [RING_DEPTH];
  logic [119:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] write_slot;
  logic [FW-1:0] fill_count;
  logic [CW-1:0] accept_counter;
  logic [23:0]   max_x, max_y, max_z;
  logic [24:0]   max_d;
  logic [24:0]   limit;

  pevrt_pkg::in_req_t req;
  logic [FW-1:0] walked;
  logic          first;
  logic [47:0]   best_gap;
  logic [AW-1:0] best;
  logic [23:0]   ex, ey, ez;
  logic [47:0]   sx, sy, sz;
  logic [49:0]   sum;
  logic          sq_start, sq_done;
  logic [24:0]   root;

  logic [47:0] rt, gap;
  logic signed [23:0] rx, ry, rz;
  logic [24:0] dx, dy, dz;

  assign rt = rd_data[119:72];
  assign rx = rd_data[71:48];
  assign ry = rd_data[47:24];
  assign rz = rd_data[23:0];
  assign gap = (req.time_us >= rt) ? req.time_us - rt : rt - req.time_us;
  assign dx = {req.pos_x[23], req.pos_x} - {rx[23], rx};
  assign dy = {req.pos_y[23], req.pos_y} - {ry[23], ry};
  assign dz = {req.pos_z[23], req.pos_z} - {rz[23], rz};

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.cmd == pevrt_pkg::CMD_REF) begin
      ring[write_slot] <= {in_data.time_us, in_data.pos_x, in_data.pos_y, in_data.pos_z};
    end
    rd_data <= ring[rd_addr];
  end

  pevrt_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sum),
    .done(sq_done), .root(root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      accept_counter <= '0;
      max_x <= '0; max_y <= '0; max_z <= '0; max_d <= '0;
      limit <= pevrt_pkg::LIMIT_RESET;
      out_valid <= 1'b0;
      sq_start <= 1'b0;
    end else begin
      sq_start <= (state == S_SUM);
      if (cfg_we) limit <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data;
            if (in_data.cmd == pevrt_pkg::CMD_REF) begin
              write_slot <= (write_slot == LAST) ? '0 : write_slot + 1'b1;
              if (fill_count != FULL) fill_count <= fill_count + 1'b1;
            end else if (fill_count == '0) begin
              out_data <= NO_REF;
              out_valid <= 1'b1;
            end else begin
              rd_addr <= (write_slot == '0) ? LAST : write_slot - 1'b1;
              walked <= FW'(1);
              first <= 1'b1;
              state <= S_WAIT;
            end
          end
        end
        S_READ: state <= S_WAIT;
        // after re-reading the match, the second pass through S_READ/S_WAIT
        S_WAIT: state <= (walked == '0) ? S_ERR : S_CMP;
        S_CMP: begin
          if (first || gap < best_gap) begin
            first <= 1'b0;
            best_gap <= gap;
            best <= rd_addr;
            if (walked == fill_count) begin
              state <= S_MATCH;
            end else begin
              walked <= walked + 1'b1;
              rd_addr <= (rd_addr == '0) ? LAST : rd_addr - 1'b1;
              state <= S_WAIT;
            end
          end else begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          rd_addr <= best;
          state <= S_READ;
          first <= 1'b1;
          walked <= '0;
        end
        default: ;
      endcase
      if (state == S_ERR) begin
        ex <= dx[24] ? 24'(-dx) : dx[23:0];
        ey <= dy[24] ? 24'(-dy) : dy[23:0];
        ez <= dz[24] ? 24'(-dz) : dz[23:0];
        state <= S_SQ;
      end
      if (state == S_SQ) begin
        sx <= ex * ex; sy <= ey * ey; sz <= ez * ez;
        state <= S_SUM;
      end
      if (state == S_SUM) begin
        sum <= 50'(sx) + 50'(sy) + 50'(sz);
        state <= S_ROOT;
      end
      if (state == S_ROOT && sq_done) state <= S_OUT;
      if (state == S_OUT) begin
        logic acc;
        logic [CW-1:0] cnt_n;
        logic [23:0] mx, my, mz;
        logic [24:0] md;
        pevrt_pkg::out_req_t o;
        acc = root <= limit;
        cnt_n = (acc && accept_counter < CLIM) ? accept_counter + 1'b1 : accept_counter;
        mx = (ex > max_x) ? ex : max_x;
        my = (ey > max_y) ? ey : max_y;
        mz = (ez > max_z) ? ez : max_z;
        md = (root > max_d) ? root : max_d;
        accept_counter <= cnt_n;
        max_x <= mx; max_y <= my; max_z <= mz; max_d <= md;
        o.time_gap_us = best_gap;
        o.err_x = ex;
        o.err_y = ey;
        o.err_z = ez;
        o.err_distance = root;
        o.accepted = acc;
        o.no_reference = 1'b0;
        o.accepted_total = 20'(cnt_n);
        o.peak_x = mx;
        o.peak_y = my;
        o.peak_z = mz;
        o.peak_distance = md;
        out_data <= o;
        out_valid <= 1'b1;
        state <= S_IDLE;
      end
    end
  end

endmodule

FILE: rtl/core/pevrt_isqrt.sv
// ----------------------------------------------------------------------------
// pevrt_isqrt: iterative integer square root
// Bit-pair restoring square root of a 50-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module pevrt_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [49:0] radicand,
  output logic        done,
  output logic [24:0] root
);

  logic [49:0] rem;
  logic [49:0] val;
  logic [24:0] res;
  logic [4:0]  cnt;
  logic        busy;
  logic [51:0] trial;

  // trial = (rem << 2 | next pair) - (res << 2 | 1)
  assign trial = {rem[49:0], val[49:48]} - {25'd0, res, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        rem  <= '0;
        val  <= radicand;
        res  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        val <= {val[47:0], 2'b00};
        if (!trial[51]) begin
          rem <= trial[49:0];
          res <= {res[23:0], 1'b1};
        end else begin
          rem <= {rem[47:0], val[49:48]};
          res <= {res[23:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        done <= (cnt == 5'd24);
        if (cnt == 5'd24) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign root = res;

endmodule
